### hw/rtl/cq_pkg.sv
// Shared types and constants for the completion queue.
package cq_pkg;

  localparam int CAP_W        = 7;
  localparam int ENTRY_PORT_W = 64;
  localparam int MAX_COUNT_W  = 5;
  localparam int OCC_W        = 7;
  localparam int STAT_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] MODE_POST  = 2'd0;
  localparam logic [1:0] MODE_POLL  = 2'd1;
  localparam logic [1:0] MODE_ARM   = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_POLL
  } cq_state_t;

  // Per-cell control: load takes the new entry, shift takes the right neighbor.
  typedef struct packed {
    logic load;
    logic shift;
  } cq_cell_ctrl_t;

  // Command from the controller to the row of cells.
  typedef struct packed {
    logic push;
    logic pop;
  } cq_chain_cmd_t;

endpackage

### hw/rtl/cq_cell.sv
// One storage cell of the queue row: holds one entry.
module cq_cell #(
  parameter int ENTRY_WIDTH = 64
) (
  input  logic                     clk,
  input  cq_pkg::cq_cell_ctrl_t    ctrl,
  input  logic [ENTRY_WIDTH-1:0]   din_new,
  input  logic [ENTRY_WIDTH-1:0]   din_right,
  output logic [ENTRY_WIDTH-1:0]   data
);
  import cq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= din_new;
    end else if (ctrl.shift) begin
      data <= din_right;
    end
  end

endmodule

### hw/rtl/cq_chain.sv
// Row of queue cells: the head sits in cell zero and a pop shifts every cell down one place.
module cq_chain #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ENTRY_WIDTH = 64,
  localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk,
  input  cq_pkg::cq_chain_cmd_t    cmd,
  input  logic [IDX_W-1:0]         push_index,
  input  logic [ENTRY_WIDTH-1:0]   din,
  output logic [ENTRY_WIDTH-1:0]   head
);
  import cq_pkg::*;

  logic [ENTRY_WIDTH-1:0] cell_data [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cq_cell_ctrl_t          ctrl;
    logic [ENTRY_WIDTH-1:0] right;

    assign ctrl.load  = cmd.push && (push_index == IDX_W'(i));
    assign ctrl.shift = cmd.pop;

    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    cq_cell #(
      .ENTRY_WIDTH(ENTRY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .din_new  (din),
      .din_right(right),
      .data     (cell_data[i])
    );
  end

  assign head = cell_data[0];

endmodule

### hw/rtl/completion_queue_with_notify.sv
// Top level of the completion queue with arm/notify and statistics.
//
//  Channel   Signals                                   Beat taken when
//  -------   ---------------------------------------   ---------------------------
//  command   start, busy, mode, entry_in, max_count    start high and busy low
//  result    result_valid, entry_out ... arm_total     every cycle result_valid is high
//  config    cfg_valid, cfg_ready, cfg_data            cfg_valid and cfg_ready high
//
// Post, arm, clear and a poll that pops nothing yield a single result beat, which shows
// in the next cycle; busy stays low, so a new command may follow at once.
// A poll that pops n entries pops them one at a time, since the row of cells
// shifts down by one place per pop; busy stays high while the remaining pops are made.
// Each result beat appears in the cycle after its pop and lasts exactly one cycle; the
// receiver cannot stall it. Synchronous reset empties the queue, clears the flags and
// statistics and sets the capacity register to 64. Capacity writes are always ready.
module completion_queue_with_notify #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ENTRY_WIDTH = 64,
  parameter int MAX_POLL    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Command channel.
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode,
  input  logic [cq_pkg::ENTRY_PORT_W-1:0]   entry_in,
  input  logic [cq_pkg::MAX_COUNT_W-1:0]    max_count,
  // Result channel.
  output logic                              result_valid,
  output logic [cq_pkg::ENTRY_PORT_W-1:0]   entry_out,
  output logic                              entry_valid,
  output logic                              last,
  output logic                              accepted,
  output logic                              notify,
  output logic [cq_pkg::OCC_W-1:0]          occupancy,
  output logic [cq_pkg::STAT_W-1:0]         posted_total,
  output logic [cq_pkg::STAT_W-1:0]         polled_total,
  output logic [cq_pkg::STAT_W-1:0]         overflow_total,
  output logic [cq_pkg::STAT_W-1:0]         arm_total,
  // Configuration channel: the capacity register.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cq_pkg::CAP_W-1:0]          cfg_data
);
  import cq_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  // Common width for comparing fill, capacity and poll counts.
  localparam int CW     = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] POLL_C  = CW'(MAX_POLL);

  // Control state.
  cq_state_t         state, state_next;
  logic [CAP_W-1:0]  capacity;
  logic [FILL_W-1:0] fill;
  logic [CW-1:0]     remain;
  logic              armed;
  logic              new_flag;
  logic [STAT_W-1:0] posted_cnt, polled_cnt, overflow_cnt, arm_cnt;

  // Command decode.
  logic              accept;
  logic [CW-1:0]     fill_ext, cap_ext, cap_sat, req, want;
  logic              post_ok;
  logic              pop_first, pop_cont, pop, last_pop;
  cq_chain_cmd_t     chain_cmd;
  logic [ENTRY_WIDTH-1:0] head;

  assign cfg_ready = 1'b1;
  assign busy      = (state == ST_POLL);
  assign accept    = start && !busy;

  assign fill_ext = CW'(fill);
  assign cap_ext  = CW'(capacity);
  // Capacity beyond the physical row is clamped to the row length.
  assign cap_sat  = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign post_ok  = fill_ext < cap_sat;

  // Number of entries this poll will pop: request clamped by the poll limit and the fill.
  always_comb begin
    req  = CW'(max_count);
    if (req > POLL_C) begin
      req = POLL_C;
    end
    want = (req > fill_ext) ? fill_ext : req;
  end

  // The first pop happens in the acceptance cycle; the rest follow one per cycle.
  assign pop_first = accept && (mode == MODE_POLL) && (want != '0);
  assign pop_cont  = (state == ST_POLL);
  assign pop       = pop_first || pop_cont;
  assign last_pop  = pop_first ? (want == CW'(1)) : (remain == CW'(1));

  assign chain_cmd.push = accept && (mode == MODE_POST) && post_ok;
  assign chain_cmd.pop  = pop;

  cq_chain #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_chain (
    .clk       (clk),
    .cmd       (chain_cmd),
    .push_index(fill[IDX_W-1:0]),
    .din       (entry_in[ENTRY_WIDTH-1:0]),
    .head      (head)
  );

  // Poll sequencer: stays in ST_POLL while more than one pop remains.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop_first && (want != CW'(1))) begin
          state_next = ST_POLL;
        end
      end
      ST_POLL: begin
        if (remain == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Queue bookkeeping, flags and statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_RESET;
      fill         <= '0;
      remain       <= '0;
      armed        <= 1'b0;
      new_flag     <= 1'b0;
      posted_cnt   <= '0;
      polled_cnt   <= '0;
      overflow_cnt <= '0;
      arm_cnt      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (pop) begin
        fill       <= fill - FILL_W'(1);
        polled_cnt <= polled_cnt + STAT_W'(1);
        remain     <= (pop_first ? want : remain) - CW'(1);
      end
      if (accept) begin
        case (mode)
          MODE_POST: begin
            if (post_ok) begin
              fill       <= fill + FILL_W'(1);
              posted_cnt <= posted_cnt + STAT_W'(1);
              new_flag   <= 1'b1;
            end else begin
              overflow_cnt <= overflow_cnt + STAT_W'(1);
            end
          end
          MODE_POLL: begin
            // The flag drops when this poll leaves the queue empty; notify is only
            // sampled after the whole poll, so its final value is set right away.
            new_flag <= new_flag && (fill_ext != want);
          end
          MODE_ARM: begin
            armed    <= 1'b1;
            new_flag <= 1'b0;
            arm_cnt  <= arm_cnt + STAT_W'(1);
          end
          MODE_CLEAR: begin
            fill         <= '0;
            armed        <= 1'b0;
            new_flag     <= 1'b0;
            posted_cnt   <= '0;
            polled_cnt   <= '0;
            overflow_cnt <= '0;
            arm_cnt      <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result beat registers. Single-result commands and each pop launch one beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= pop || accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      entry_out   <= ENTRY_PORT_W'(head);
      entry_valid <= 1'b1;
      last        <= last_pop;
      accepted    <= 1'b0;
    end else begin
      entry_out   <= '0;
      entry_valid <= 1'b0;
      last        <= 1'b1;
      accepted    <= accept && (mode == MODE_POST) && post_ok;
    end
  end

  // Occupancy, statistics and notify come straight from the state registers, which
  // hold the values after the beat's own update while that beat is on the ports.
  assign notify         = armed && new_flag;
  assign occupancy      = OCC_W'(fill);
  assign posted_total   = posted_cnt;
  assign polled_total   = polled_cnt;
  assign overflow_total = overflow_cnt;
  assign arm_total      = arm_cnt;

endmodule

### test/cq_checker.sv
// Checker for the completion queue: predicts every result beat and compares it.
module cq_checker #(
  parameter int Q_DEPTH   = 64,
  parameter int MAX_DRAIN = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [1:0]                      mode,
  input  logic [cq_pkg::ENTRY_PORT_W-1:0] entry_in,
  input  logic [cq_pkg::MAX_COUNT_W-1:0]  max_count,
  input  logic                            result_valid,
  input  logic [cq_pkg::ENTRY_PORT_W-1:0] entry_out,
  input  logic                            entry_valid,
  input  logic                            last,
  input  logic                            accepted,
  input  logic                            notify,
  input  logic [cq_pkg::OCC_W-1:0]        occupancy,
  input  logic [cq_pkg::STAT_W-1:0]       posted_total,
  input  logic [cq_pkg::STAT_W-1:0]       polled_total,
  input  logic [cq_pkg::STAT_W-1:0]       overflow_total,
  input  logic [cq_pkg::STAT_W-1:0]       arm_total,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cq_pkg::CAP_W-1:0]        cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              beats_seen
);
  import cq_pkg::*;

  localparam int IDX_W      = $clog2(Q_DEPTH);
  // Far more than one command can leave outstanding.
  localparam int OWED_DEPTH = 256;

  typedef struct {
    logic [ENTRY_PORT_W-1:0] entry;
    logic                    entry_valid;
    logic                    last;
    logic                    accepted;
    logic                    notify;
    logic [OCC_W-1:0]        occupancy;
    logic [STAT_W-1:0]       posted;
    logic [STAT_W-1:0]       polled;
    logic [STAT_W-1:0]       overflow;
    logic [STAT_W-1:0]       arms;
  } cq_beat_t;

  // Predicted beats in arrival order, kept as a ring with running read and write counts.
  cq_beat_t owed_beats [OWED_DEPTH];
  int       owed_rd;
  int       owed_wr;
  cq_beat_t seen_beat;

  logic [ENTRY_PORT_W-1:0] slot [Q_DEPTH];
  logic [IDX_W-1:0]        head;
  logic [IDX_W-1:0]        tail;
  logic [OCC_W-1:0]        fill;
  logic                    armed;
  logic                    fresh;
  logic [STAT_W-1:0]       posted_cnt;
  logic [STAT_W-1:0]       polled_cnt;
  logic [STAT_W-1:0]       overflow_cnt;
  logic [STAT_W-1:0]       arm_cnt;
  logic [CAP_W-1:0]        capacity;
  int                      err_count;
  int                      beat_count;

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] idx);
    return (int'(idx) == Q_DEPTH - 1) ? '0 : idx + 1'b1;
  endfunction

  // Snapshot of the queue state after one pop or one single-beat command.
  function automatic cq_beat_t make_beat(logic [ENTRY_PORT_W-1:0] value, logic ev,
                                         logic lst, logic acc);
    cq_beat_t b;
    b.entry       = value;
    b.entry_valid = ev;
    b.last        = lst;
    b.accepted    = acc;
    b.notify      = 1'b0;
    b.occupancy   = fill;
    b.posted      = posted_cnt;
    b.polled      = polled_cnt;
    b.overflow    = overflow_cnt;
    b.arms        = arm_cnt;
    return b;
  endfunction

  function automatic void append_beat(cq_beat_t b);
    owed_beats[owed_wr % OWED_DEPTH] = b;
    owed_wr++;
  endfunction

  // Applies one command to the queue state and appends the beats it owes.
  function automatic void run_cq_command(logic [1:0] op, logic [ENTRY_PORT_W-1:0] value,
                                         logic [MAX_COUNT_W-1:0] count);
    int unsigned      take;
    logic [CAP_W-1:0] room;
    int               first;
    first = owed_wr;
    room = (int'(capacity) > Q_DEPTH) ? CAP_W'(Q_DEPTH) : capacity;
    case (op)
      MODE_POST: begin
        if (fill < room) begin
          slot[tail] = value;
          tail = next_slot(tail);
          fill++;
          posted_cnt++;
          fresh = 1'b1;
          append_beat(make_beat('0, 1'b0, 1'b1, 1'b1));
        end else begin
          overflow_cnt++;
          append_beat(make_beat('0, 1'b0, 1'b1, 1'b0));
        end
      end
      MODE_POLL: begin
        take = count;
        if (take > MAX_DRAIN) take = MAX_DRAIN;
        if (take > fill) take = fill;
        for (int k = 0; k < int'(take); k++) begin
          value = slot[head];
          head = next_slot(head);
          fill--;
          polled_cnt++;
          if (fill == 0) fresh = 1'b0;
          append_beat(make_beat(value, 1'b1, k + 1 == int'(take), 1'b0));
        end
        if (take == 0) begin
          if (fill == 0) fresh = 1'b0;
          append_beat(make_beat('0, 1'b0, 1'b1, 1'b0));
        end
      end
      MODE_ARM: begin
        armed = 1'b1;
        fresh = 1'b0;
        arm_cnt++;
        append_beat(make_beat('0, 1'b0, 1'b1, 1'b0));
      end
      default: begin
        head         = '0;
        tail         = '0;
        fill         = '0;
        armed        = 1'b0;
        fresh        = 1'b0;
        posted_cnt   = '0;
        polled_cnt   = '0;
        overflow_cnt = '0;
        arm_cnt      = '0;
        append_beat(make_beat('0, 1'b0, 1'b1, 1'b0));
      end
    endcase
    // Notify reflects the flags at the end of the whole command.
    for (int i = first; i < owed_wr; i++) begin
      owed_beats[i % OWED_DEPTH].notify = armed & fresh;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      owed_rd      = 0;
      owed_wr      = 0;
      head         = '0;
      tail         = '0;
      fill         = '0;
      armed        = 1'b0;
      fresh        = 1'b0;
      posted_cnt   = '0;
      polled_cnt   = '0;
      overflow_cnt = '0;
      arm_cnt      = '0;
      capacity     = CAP_RESET;
      err_count    = 0;
      beat_count   = 0;
    end else begin
      if (result_valid) begin
        beat_count++;
        if (owed_wr == owed_rd) begin
          $error("result beat arrived with no command outstanding");
          err_count++;
        end else begin
          seen_beat = owed_beats[owed_rd % OWED_DEPTH];
          owed_rd++;
          check_field("entry_out", 64'(seen_beat.entry), 64'(entry_out));
          check_field("entry_valid", 64'(seen_beat.entry_valid), 64'(entry_valid));
          check_field("last", 64'(seen_beat.last), 64'(last));
          check_field("accepted", 64'(seen_beat.accepted), 64'(accepted));
          check_field("notify", 64'(seen_beat.notify), 64'(notify));
          check_field("occupancy", 64'(seen_beat.occupancy), 64'(occupancy));
          check_field("posted_total", 64'(seen_beat.posted), 64'(posted_total));
          check_field("polled_total", 64'(seen_beat.polled), 64'(polled_total));
          check_field("overflow_total", 64'(seen_beat.overflow), 64'(overflow_total));
          check_field("arm_total", 64'(seen_beat.arms), 64'(arm_total));
        end
      end
      if (start && !busy) run_cq_command(mode, entry_in, max_count);
      if (cfg_valid && cfg_ready) capacity = cfg_data;
    end
    mismatches <= err_count;
    pending    <= owed_wr - owed_rd;
    beats_seen <= beat_count;
  end

endmodule

### test/completion_queue_with_notify_tb.sv
// Testbench top for the completion queue: stimulus, capacity settings and verdict.
module completion_queue_with_notify_tb;
  import cq_pkg::*;

  localparam int Q_DEPTH        = 64;
  localparam int ENTRY_BITS     = 64;
  localparam int MAX_DRAIN      = 16;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_LIMIT   = 2000;
  localparam int N_CHUNKS       = 9;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              mode = MODE_POST;
  logic [ENTRY_PORT_W-1:0] entry_in = '0;
  logic [MAX_COUNT_W-1:0]  max_count = '0;
  logic                    result_valid;
  logic [ENTRY_PORT_W-1:0] entry_out;
  logic                    entry_valid;
  logic                    last;
  logic                    accepted;
  logic                    notify;
  logic [OCC_W-1:0]        occupancy;
  logic [STAT_W-1:0]       posted_total;
  logic [STAT_W-1:0]       polled_total;
  logic [STAT_W-1:0]       overflow_total;
  logic [STAT_W-1:0]       arm_total;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_data = '0;

  int mismatches;
  int pending;
  int beats_seen;

  int gap_pct = 0;
  int n_cmds  = 0;
  int n_cfg   = 0;
  int tb_errors = 0;

  // Random plan: each chunk runs under one capacity with its own share of posts.
  // The early chunks are post-heavy so the queue actually fills to its depth; the
  // next capacity is lower than the fill left behind, which exercises refusal
  // while entries are still held. Zero capacity refuses every post.
  int chunk_cap  [N_CHUNKS] = '{64, 127, 4, 1, 0, 20, 64, 100, 16};
  int chunk_post [N_CHUNKS] = '{60, 95, 55, 50, 50, 65, 90, 60, 55};
  int chunk_len  [N_CHUNKS] = '{40, 55, 40, 40, 30, 50, 60, 45, 45};
  int phase_gap  [3]        = '{21, 80, 0};

  always #5 clk = ~clk;

  completion_queue_with_notify #(
    .QUEUE_DEPTH(Q_DEPTH),
    .ENTRY_WIDTH(ENTRY_BITS),
    .MAX_POLL   (MAX_DRAIN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .entry_in      (entry_in),
    .max_count     (max_count),
    .result_valid  (result_valid),
    .entry_out     (entry_out),
    .entry_valid   (entry_valid),
    .last          (last),
    .accepted      (accepted),
    .notify        (notify),
    .occupancy     (occupancy),
    .posted_total  (posted_total),
    .polled_total  (polled_total),
    .overflow_total(overflow_total),
    .arm_total     (arm_total),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // The checker sits beside the block and sees exactly the same pins.
  cq_checker #(
    .Q_DEPTH  (Q_DEPTH),
    .MAX_DRAIN(MAX_DRAIN)
  ) checker_i (.*);

  // Sender gaps: while idling, start is low and the payload carries junk, which
  // the block must ignore. The gap is drawn before every command, so idle cycles
  // land right after single-beat commands as well as after multi-beat polls.
  task automatic sender_gap();
    while ($urandom_range(99) < gap_pct) begin
      start     <= 1'b0;
      mode      <= 2'($urandom_range(3));
      entry_in  <= {$urandom, $urandom};
      max_count <= MAX_COUNT_W'($urandom_range(31));
      @(posedge clk);
    end
  endtask

  // Presents one command beat and holds it until busy is seen low at an edge.
  // Start is left high on return so a following command can go out back to back.
  task automatic issue(logic [1:0] op, logic [ENTRY_PORT_W-1:0] value,
                       logic [MAX_COUNT_W-1:0] count);
    sender_gap();
    start     <= 1'b1;
    mode      <= op;
    entry_in  <= value;
    max_count <= count;
    do @(posedge clk); while (busy);
    n_cmds++;
  endtask

  // Stops sending and waits until every predicted result beat has shown up.
  // Every command yields at least one beat, so an empty prediction store means the
  // block is idle; a further wait covers the registered result beats.
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < SETTLE_LIMIT);
    repeat (4) @(posedge clk);
  endtask

  // Capacity writes only happen with the queue idle.
  task automatic write_capacity(logic [CAP_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // One random command. Most polls ask for a few entries so that posts outrun
  // them and the queue fills; some ask for more than the per-poll limit.
  task automatic random_command(int post_pct);
    int                     pick;
    logic [ENTRY_PORT_W-1:0] value;
    logic [MAX_COUNT_W-1:0]  count;
    pick = $urandom_range(99);
    if (pick < 10) value = '1;
    else if (pick < 15) value = '0;
    else value = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 70) count = MAX_COUNT_W'($urandom_range(3));
    else if (pick < 90) count = MAX_COUNT_W'($urandom_range(MAX_DRAIN, 4));
    else count = MAX_COUNT_W'($urandom_range(31, MAX_DRAIN + 1));
    if ($urandom_range(99) < post_pct) begin
      issue(MODE_POST, value, count);
    end else begin
      pick = $urandom_range(9);
      if (pick < 6) issue(MODE_POLL, value, count);
      else if (pick < 9) issue(MODE_ARM, value, count);
      else issue(MODE_CLEAR, value, count);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at full capacity first.
    write_capacity(CAP_RESET);
    issue(MODE_POLL, '0, 5'd0);                      // nothing asked, nothing held
    issue(MODE_POLL, '0, 5'd16);                     // poll on an empty queue
    issue(MODE_ARM, '0, 5'd0);
    issue(MODE_POST, '1, 5'd0);                      // armed plus new entry: notify
    issue(MODE_POST, '0, 5'd0);
    issue(MODE_POST, 64'haaaa_aaaa_aaaa_aaaa, 5'd0);
    issue(MODE_POLL, '0, 5'd0);                      // zero count with entries held
    issue(MODE_POLL, '0, 5'd31);                     // count saturates, queue drains
    issue(MODE_POST, 64'h8000_0000_0000_0001, 5'd0);
    issue(MODE_POLL, '0, 5'd1);                      // single-entry poll
    issue(MODE_POST, 64'h5555_5555_5555_5555, 5'd0);
    issue(MODE_ARM, '0, 5'd0);                       // arming clears the new flag
    issue(MODE_CLEAR, '0, 5'd0);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);

    // Zero capacity refuses everything; the held entry still drains.
    write_capacity(7'd0);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);
    issue(MODE_POLL, '0, 5'd2);

    write_capacity(7'd1);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);   // full at one entry
    issue(MODE_POLL, '0, 5'd16);

    // Above the depth the capacity saturates.
    write_capacity(7'd127);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);

    // Capacity dropped below the fill: posts bounce until the fill falls.
    write_capacity(7'd2);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);
    issue(MODE_POLL, '0, 5'd2);
    issue(MODE_POST, {$urandom, $urandom}, 5'd0);

    // Random part: three sender pacing phases, three capacity chunks each.
    chunk_cap[5] = $urandom_range(63, 2);
    chunk_cap[7] = $urandom_range(127);
    for (int c = 0; c < N_CHUNKS; c++) begin
      gap_pct = phase_gap[c / 3];
      write_capacity(CAP_W'(chunk_cap[c]));
      for (int i = 0; i < chunk_len[c]; i++) random_command(chunk_post[c]);
    end

    gap_pct = 0;
    settle();
    if (pending != 0) begin
      $error("%0d predicted result beats never arrived", pending);
      tb_errors++;
    end

    $display("Ran %0d commands (posts, polls, arms, clears) across %0d capacity settings,",
             n_cmds, n_cfg);
    $display("with sender gaps of 21, 80 and 0 percent; %0d result beats were checked.",
             beats_seen);
    if (mismatches == 0 && tb_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case the block hangs or stops producing result beats.
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### completion_queue_with_notify.f
hw/rtl/cq_pkg.sv
hw/rtl/cq_cell.sv
hw/rtl/cq_chain.sv
hw/rtl/completion_queue_with_notify.sv
test/cq_checker.sv
test/completion_queue_with_notify_tb.sv
